### rtl/core/sft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Switch forwarding table package
// Shared widths, operation and status codes, and the cell word types.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LINK_W = 4;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_LEARN  = 3'd0,
    MODE_LOOKUP = 3'd1,
    MODE_PARENT = 3'd2,
    MODE_CHILD  = 3'd3,
    MODE_BAD    = 3'd4,
    MODE_QUERY  = 3'd5,
    MODE_UPDATE = 3'd6,
    MODE_NOP    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ROLE_CHILD  = 2'd0,
    ROLE_PARENT = 2'd1,
    ROLE_BAD    = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [LINK_W-1:0] link;
    logic              vld;
    role_e             role;
  } entry_t;

  typedef struct packed {
    logic              capture;   // register the compare result
    logic [ADDR_W-1:0] key;
    logic              shift;     // every cell takes its neighbor's entry
    logic              upd_link;  // matching cell writes link and valid bit
    logic              upd_role;  // matching cell writes role
    logic [LINK_W-1:0] link;
    logic              vld;
    role_e             role;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/switch_forwarding_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Switch forwarding table
// Learning forwarding table built as a row of entry cells.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Each word passes
// through S_MATCH, in which all cells compare their key with the address,
// and S_EXEC, in which the matching cell, if any, is read or updated. The
// next word can be taken in S_EXEC, so the table takes a new word while it
// finishes the last. The result appears in the cycle after S_EXEC, for one
// cycle only, marked by result_valid_o; the receiver cannot stall it. New
// entries enter at the head cell while all others move one cell down.
// ----------------------------------------------------------------------------
module switch_forwarding_table (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire  [2:0]                  mode_i,
  input  wire  [sft_pkg::ADDR_W-1:0]  dest_address_i,
  input  wire                         valid_flag_i,
  input  wire  [sft_pkg::LINK_W-1:0]  out_link_i,
  output logic                        result_valid_o,
  output logic                        found_o,
  output logic [sft_pkg::LINK_W-1:0]  link_result_o,
  output logic                        bad_result_o,
  output logic [1:0]                  status_o
);
  import sft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  mode_e             mode_q;
  logic [ADDR_W-1:0] key_q;
  logic              vld_q;
  logic [LINK_W-1:0] link_q;
  logic [CNT_W-1:0]  count_q, count_d;

  logic       accept;
  cell_ctrl_t ctrl;
  entry_t     entries [DEPTH];
  logic       match [DEPTH];
  entry_t     head_entry;

  logic              hit;
  logic [LINK_W-1:0] hit_link;
  logic [1:0]        hit_role;
  logic [LINK_W-1:0] link_res;
  logic              bad_res;
  status_e           status;

  assign busy   = (state_q == S_MATCH);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  state_d = start ? S_MATCH : S_IDLE;
      S_MATCH: state_d = S_EXEC;
      S_EXEC:  state_d = start ? S_MATCH : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= dest_address_i;
      vld_q  <= valid_flag_i;
      link_q <= out_link_i;
    end
  end

  // At most one cell matches, so an AND-OR over the row selects its entry.
  always_comb begin
    hit      = 1'b0;
    hit_link = '0;
    hit_role = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit      = hit | match[i];
      hit_link = hit_link | ({LINK_W{match[i]}} & entries[i].link);
      hit_role = hit_role | ({2{match[i]}} & entries[i].role);
    end
  end

  assign head_entry = '{key: key_q, link: link_q, vld: vld_q, role: ROLE_CHILD};

  always_comb begin
    ctrl          = '0;
    ctrl.capture  = (state_q == S_MATCH);
    ctrl.key      = key_q;
    ctrl.link     = link_q;
    ctrl.vld      = vld_q;
    ctrl.role     = ROLE_CHILD;
    count_d       = count_q;
    link_res      = '0;
    bad_res       = 1'b0;
    status        = ST_OK;
    if (state_q == S_EXEC) begin
      unique case (mode_q)
        MODE_LEARN: begin
          if (hit) begin
            ctrl.upd_link = 1'b1;
            ctrl.upd_role = 1'b1;
          end else if (count_q < CNT_W'(DEPTH)) begin
            ctrl.shift = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end else begin
            status = ST_FULL;
          end
        end
        MODE_LOOKUP: begin
          if (hit) link_res = hit_link;
          else     status   = ST_MISSING;
        end
        MODE_PARENT, MODE_CHILD, MODE_BAD: begin
          ctrl.upd_role = hit;
          if (mode_q == MODE_PARENT)     ctrl.role = ROLE_PARENT;
          else if (mode_q == MODE_BAD)   ctrl.role = ROLE_BAD;
          else                           ctrl.role = ROLE_CHILD;
          if (!hit) status = ST_MISSING;
        end
        MODE_QUERY: begin
          bad_res = hit && (hit_role == ROLE_BAD);
          if (!hit) status = ST_MISSING;
        end
        MODE_UPDATE: begin
          ctrl.upd_link = hit;
          ctrl.upd_role = hit;
          if (!hit) status = ST_MISSING;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sft_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .occupied_i (CNT_W'(i) < count_q),
      .prev_i     ((i == 0) ? head_entry : entries[(i == 0) ? 0 : i - 1]),
      .entry_o    (entries[i]),
      .match_o    (match[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      found_o       <= hit;
      link_result_o <= link_res;
      bad_result_o  <= bad_res;
      status_o      <= status;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sft_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Forwarding table cell
// Holds one table entry, compares it with the broadcast key, and on an
// insert takes the entry of its upstream neighbor.
// ----------------------------------------------------------------------------
module sft_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sft_pkg::cell_ctrl_t ctrl_i,
  input  wire                 occupied_i,
  input  sft_pkg::entry_t     prev_i,
  output sft_pkg::entry_t     entry_o,
  output logic                match_o
);
  import sft_pkg::*;

  entry_t entry_q, entry_d;
  logic   match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= occupied_i && (entry_q.key == ctrl_i.key);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = prev_i;
    end else if (match_q) begin
      if (ctrl_i.upd_link) begin
        entry_d.link = ctrl_i.link;
        entry_d.vld  = ctrl_i.vld;
      end
      if (ctrl_i.upd_role) begin
        entry_d.role = ctrl_i.role;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule
`default_nettype wire
